[design/voice_channel_call_tracker_defines.svh]
// Assertion macros used by the call tracker checker.
`ifndef VOICE_CHANNEL_CALL_TRACKER_DEFINES_SVH
`define VOICE_CHANNEL_CALL_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define VCCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define VCCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/vcct_pkg.sv]
// Shared types, codes and defaults of the voice channel call tracker.
package vcct_pkg;

    localparam int LINKS_DEF        = 4;
    localparam int E1_PER_LINK_DEF  = 63;
    localparam int SLOTS_PER_E1_DEF = 32;
    localparam int CH_IDX_W         = 17;
    localparam int Q_DEPTH          = 2;

    localparam logic [15:0] MIN_PKT_LEN   = 16'd36;
    localparam logic [7:0]  TYPE_VOICE    = 8'h03;
    localparam logic [7:0]  DIR_UP        = 8'h01;
    localparam logic [7:0]  MARK_LAST     = 8'h02;
    localparam logic [15:0] LOST_MAX      = 16'hffff;

    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;
    localparam logic [31:0] AGE_LIMIT_RST   = 32'd18000;
    localparam logic [15:0] BUFFER_SIZE_RST = 16'd4096;

    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_AGE_LIMIT   = 2'd1;
    localparam logic [1:0] REG_BUFFER_SIZE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_HDR  = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_STALE    = 3'd4;

    typedef struct packed {
        logic [15:0] packet_len;
        logic [7:0]  type_byte;
        logic [63:0] call_id;
        logic [7:0]  direction;
        logic [7:0]  case_flag;
        logic [7:0]  end_mark;
        logic [7:0]  seq_no;
        logic [15:0] payload_len;
        logic [31:0] now_seconds;
    } vcct_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] channel;
        logic        new_call;
        logic        old_call_closed;
        logic        seq_gap;
        logic        flush;
        logic [15:0] write_offset;
        logic [15:0] accepted_len;
        logic        call_done;
        logic [15:0] up_lost_total;
        logic [15:0] dn_lost_total;
    } vcct_out_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [CH_IDX_W-1:0] channel;
        logic [63:0]         call_id;
        logic                up;
        logic                last;
        logic                stale;
        logic [7:0]          seq_no;
        logic [15:0]         payload_len;
    } vcct_cmd_t;

    typedef struct packed {
        logic [63:0] call_id;
        logic [7:0]  up_expected;
        logic [7:0]  down_expected;
        logic [15:0] up_lost;
        logic [15:0] dn_lost;
        logic [15:0] up_fill;
        logic [15:0] down_fill;
        logic        up_ended;
        logic        down_ended;
    } vcct_entry_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_UPDATE
    } vcct_back_state_t;

endpackage

[design/voice_channel_call_tracker.sv]
// Voice channel call tracker top level: configuration registers, front end, queue, update engine.
// In the update engine a header transaction first reads the channel entry from the single-port
// state memory into a register, then updates it, writes it back and loads the result
// register. After reset the engine zeroes all LINKS*E1_PER_LINK*SLOTS_PER_E1 channel entries,
// one per cycle (8064 entries at the defaults), with s_ready low; configuration writes are taken
// throughout. A two-entry queue lets the front end accept headers while a result waits.
module voice_channel_call_tracker #(
    parameter int LINKS        = vcct_pkg::LINKS_DEF,
    parameter int E1_PER_LINK  = vcct_pkg::E1_PER_LINK_DEF,
    parameter int SLOTS_PER_E1 = vcct_pkg::SLOTS_PER_E1_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vcct_pkg::vcct_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vcct_pkg::vcct_out_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    logic [15:0] max_payload_reg, max_payload_next;
    logic [31:0] age_limit_reg, age_limit_next;
    logic [15:0] buffer_size_reg, buffer_size_next;
    logic        wr_en;

    logic                q_push, q_full, q_pop, q_valid, clearing;
    vcct_pkg::vcct_cmd_t q_in, q_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        max_payload_next = max_payload_reg;
        age_limit_next   = age_limit_reg;
        buffer_size_next = buffer_size_reg;
        prdata           = '0;
        unique case (paddr[3:2])
            vcct_pkg::REG_MAX_PAYLOAD: begin
                prdata = {16'd0, max_payload_reg};
                if (wr_en) begin
                    max_payload_next = pwdata[15:0];
                end
            end
            vcct_pkg::REG_AGE_LIMIT: begin
                prdata = age_limit_reg;
                if (wr_en) begin
                    age_limit_next = pwdata;
                end
            end
            vcct_pkg::REG_BUFFER_SIZE: begin
                prdata = {16'd0, buffer_size_reg};
                if (wr_en) begin
                    buffer_size_next = pwdata[15:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= vcct_pkg::MAX_PAYLOAD_RST;
            age_limit_reg   <= vcct_pkg::AGE_LIMIT_RST;
            buffer_size_reg <= vcct_pkg::BUFFER_SIZE_RST;
        end else begin
            max_payload_reg <= max_payload_next;
            age_limit_reg   <= age_limit_next;
            buffer_size_reg <= buffer_size_next;
        end
    end

    vcct_front #(
        .LINKS        (LINKS),
        .E1_PER_LINK  (E1_PER_LINK),
        .SLOTS_PER_E1 (SLOTS_PER_E1)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .max_payload (max_payload_reg),
        .age_limit   (age_limit_reg),
        .q_full      (q_full),
        .clearing    (clearing),
        .push        (q_push),
        .cmd         (q_in)
    );

    vcct_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .valid     (q_valid)
    );

    vcct_back #(
        .LINKS        (LINKS),
        .E1_PER_LINK  (E1_PER_LINK),
        .SLOTS_PER_E1 (SLOTS_PER_E1)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .buffer_size (buffer_size_reg),
        .clearing    (clearing),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );
endmodule

[design/vcct_front.sv]
// Front end: accepts packet headers, checks them and maps them to a channel.
module vcct_front #(
    parameter int LINKS        = vcct_pkg::LINKS_DEF,
    parameter int E1_PER_LINK  = vcct_pkg::E1_PER_LINK_DEF,
    parameter int SLOTS_PER_E1 = vcct_pkg::SLOTS_PER_E1_DEF
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  vcct_pkg::vcct_in_t  s_data,
    input  logic [15:0]         max_payload,
    input  logic [31:0]         age_limit,
    input  logic                q_full,
    input  logic                clearing,
    output logic                push,
    output vcct_pkg::vcct_cmd_t cmd
);
    localparam int CW = vcct_pkg::CH_IDX_W;

    logic [5:0]  link;
    logic [5:0]  e1;
    logic [4:0]  slot;
    logic [33:0] age;

    assign link = s_data.call_id[31:26];
    assign e1   = s_data.call_id[25:20];
    assign slot = s_data.call_id[19:15];
    assign age  = {2'b00, s_data.now_seconds} - {2'b00, s_data.call_id[63:32]};

    assign s_ready = !q_full && !clearing;
    assign push    = s_valid && s_ready;

    always_comb begin
        cmd             = '0;
        cmd.call_id     = s_data.call_id;
        cmd.up          = (s_data.direction == vcct_pkg::DIR_UP);
        cmd.last        = (s_data.end_mark == vcct_pkg::MARK_LAST);
        cmd.seq_no      = s_data.seq_no;
        cmd.payload_len = s_data.payload_len;
        cmd.stale       = ($signed(age) >= $signed({2'b00, age_limit}));
        cmd.channel     = (CW'(link) * CW'(E1_PER_LINK) + CW'(e1)) * CW'(SLOTS_PER_E1)
                          + CW'(slot);
        priority if (s_data.packet_len < vcct_pkg::MIN_PKT_LEN
                     || s_data.type_byte != vcct_pkg::TYPE_VOICE) begin
            cmd.status = vcct_pkg::ST_BAD_HDR;
        end else if (s_data.payload_len > max_payload) begin
            cmd.status = vcct_pkg::ST_TOO_LONG;
        end else if (32'(link) >= 32'(LINKS) || 32'(e1) >= 32'(E1_PER_LINK)
                     || 32'(slot) >= 32'(SLOTS_PER_E1)) begin
            cmd.status = vcct_pkg::ST_RANGE;
        end else begin
            cmd.status = vcct_pkg::ST_OK;
        end
    end
endmodule

[design/vcct_fifo.sv]
// Short command queue between the front end and the channel update engine.
module vcct_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  vcct_pkg::vcct_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output vcct_pkg::vcct_cmd_t pop_data,
    output logic                valid
);
    localparam int D  = vcct_pkg::Q_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int NW = $clog2(D + 1);

    vcct_pkg::vcct_cmd_t slots_reg [D];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign full     = (count_reg == NW'(D));
    assign valid    = (count_reg != '0);
    assign pop_data = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(D - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(D - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

[design/vcct_back.sv]
// Channel update engine: per-channel state memory, read-modify-write, result register.
module vcct_back #(
    parameter int LINKS        = vcct_pkg::LINKS_DEF,
    parameter int E1_PER_LINK  = vcct_pkg::E1_PER_LINK_DEF,
    parameter int SLOTS_PER_E1 = vcct_pkg::SLOTS_PER_E1_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  vcct_pkg::vcct_cmd_t q_data,
    output logic                q_pop,
    input  logic [15:0]         buffer_size,
    output logic                clearing,
    output logic                m_valid,
    input  logic                m_ready,
    output vcct_pkg::vcct_out_t m_data
);
    localparam int CHANNELS = LINKS * E1_PER_LINK * SLOTS_PER_E1;
    localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    vcct_pkg::vcct_entry_t mem [CHANNELS];

    vcct_pkg::vcct_back_state_t state_reg, state_next;
    logic [AW-1:0]         clr_idx_reg, clr_idx_next;
    vcct_pkg::vcct_cmd_t   cmd_reg;
    vcct_pkg::vcct_entry_t rd_data_reg;
    logic                  out_valid_reg, out_valid_next;
    vcct_pkg::vcct_out_t   out_data_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    vcct_pkg::vcct_entry_t mem_wdata;
    logic                  upd_we;
    vcct_pkg::vcct_entry_t upd;
    vcct_pkg::vcct_out_t   res;

    assign clearing = (state_reg == vcct_pkg::BK_CLEAR);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        logic [15:0] fill;
        logic [15:0] left;
        logic [15:0] take;
        logic        gap;
        upd    = rd_data_reg;
        res    = '0;
        upd_we = 1'b0;
        fill   = '0;
        left   = '0;
        take   = '0;
        gap    = 1'b0;
        res.status = cmd_reg.status;
        if (cmd_reg.status == vcct_pkg::ST_OK) begin
            res.channel = cmd_reg.channel[12:0];
            if (cmd_reg.stale && rd_data_reg.call_id == '0) begin
                res.status        = vcct_pkg::ST_STALE;
                res.up_lost_total = rd_data_reg.up_lost;
                res.dn_lost_total = rd_data_reg.dn_lost;
            end else begin
                upd_we = 1'b1;
                if (cmd_reg.stale) begin
                    upd.up_ended   = 1'b1;
                    upd.down_ended = 1'b1;
                end
                if (rd_data_reg.call_id != cmd_reg.call_id) begin
                    res.old_call_closed = (rd_data_reg.call_id != '0);
                    res.new_call        = 1'b1;
                    upd                 = '0;
                    upd.call_id         = cmd_reg.call_id;
                    upd.up_expected     = 8'd1;
                    upd.down_expected   = 8'd1;
                end
                if (cmd_reg.up) begin
                    gap = (upd.up_expected != cmd_reg.seq_no);
                    if (gap && upd.up_lost != vcct_pkg::LOST_MAX) begin
                        upd.up_lost = upd.up_lost + 1'b1;
                    end
                    upd.up_expected = cmd_reg.seq_no + 1'b1;
                    fill = upd.up_fill;
                end else begin
                    gap = (upd.down_expected != cmd_reg.seq_no);
                    if (gap && upd.dn_lost != vcct_pkg::LOST_MAX) begin
                        upd.dn_lost = upd.dn_lost + 1'b1;
                    end
                    upd.down_expected = cmd_reg.seq_no + 1'b1;
                    fill = upd.down_fill;
                end
                res.seq_gap = gap;
                if (fill >= buffer_size) begin
                    upd.up_fill   = '0;
                    upd.down_fill = '0;
                    fill          = '0;
                    res.flush     = 1'b1;
                end
                left = (buffer_size > fill) ? buffer_size - fill : '0;
                take = (left < cmd_reg.payload_len) ? left : cmd_reg.payload_len;
                if (cmd_reg.up) begin
                    upd.up_fill = fill + take;
                    if (cmd_reg.last) begin
                        upd.up_ended = 1'b1;
                    end
                end else begin
                    upd.down_fill = fill + take;
                    if (cmd_reg.last) begin
                        upd.down_ended = 1'b1;
                    end
                end
                res.write_offset = fill;
                res.accepted_len = take;
                if (upd.up_ended && upd.down_ended) begin
                    upd.call_id       = '0;
                    upd.up_ended      = 1'b0;
                    upd.down_ended    = 1'b0;
                    upd.up_expected   = '0;
                    upd.down_expected = '0;
                    res.call_done     = 1'b1;
                end
                res.up_lost_total = upd.up_lost;
                res.dn_lost_total = upd.dn_lost;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cmd_reg.channel[AW-1:0];
        mem_wdata      = upd;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (state_reg)
            vcct_pkg::BK_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(CHANNELS - 1)) begin
                    state_next = vcct_pkg::BK_IDLE;
                end
            end
            vcct_pkg::BK_IDLE: begin
                if (q_valid && (!out_valid_reg || m_ready)) begin
                    q_pop      = 1'b1;
                    state_next = vcct_pkg::BK_UPDATE;
                end
            end
            vcct_pkg::BK_UPDATE: begin
                mem_we         = upd_we;
                out_valid_next = 1'b1;
                state_next     = vcct_pkg::BK_IDLE;
            end
            default: begin
                state_next = vcct_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vcct_pkg::BK_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_data;
        end
        if (state_reg == vcct_pkg::BK_UPDATE) begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop) begin
            rd_data_reg <= mem[q_data.channel[AW-1:0]];
        end
    end
endmodule

[design/vcct_checker.sv]
// Port-level checker of the call tracker and its bind to the top level.
`include "voice_channel_call_tracker_defines.svh"

module vcct_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input vcct_pkg::vcct_out_t m_data
);
    logic rejected;
    logic reject_zero;
    logic stale_zero;

    assign rejected    = (m_data.status == vcct_pkg::ST_BAD_HDR)
                         || (m_data.status == vcct_pkg::ST_TOO_LONG)
                         || (m_data.status == vcct_pkg::ST_RANGE);
    assign reject_zero = (m_data.channel == '0) && !m_data.new_call && !m_data.call_done
                         && (m_data.up_lost_total == '0) && (m_data.dn_lost_total == '0);
    assign stale_zero  = !m_data.new_call && !m_data.flush && !m_data.call_done
                         && (m_data.accepted_len == '0);

    `VCCT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `VCCT_ASSERT_NOW(a_reject_clean, m_valid && rejected, reject_zero, "rejected transaction carries data")
    `VCCT_ASSERT_NOW(a_stale_clean, m_valid && m_data.status == vcct_pkg::ST_STALE, stale_zero, "stale drop changed a call")
    `VCCT_ASSERT_NOW(a_old_needs_new, m_valid && m_data.old_call_closed, m_data.new_call && m_data.status == vcct_pkg::ST_OK, "displaced call without new call")
endmodule

bind voice_channel_call_tracker vcct_checker u_vcct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
